// File: hw/rtl/dhtd_pkg.sv
package dhtd_pkg;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned DZ_W   = 32;
    localparam int unsigned MS_W   = 16;
    localparam int unsigned PROG_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH_MS    = 2'd2;

    localparam logic [DZ_W-1:0] DEAD_ZONE_SQ_RST = 32'd25600;
    localparam logic [MS_W-1:0] START_MS_RST     = 16'd300;
    localparam logic [MS_W-1:0] FINISH_MS_RST    = 16'd1500;

    // Q1.15 one
    localparam logic [PROG_W-1:0] Q_ONE = 16'h8000;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: hw/rtl/dwell_hold_toggle_detector.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------
// sample in | in        | i_in_valid / o_in_stall   | i_tip_x, i_tip_y, i_now_ms
// result    | out       | o_out_valid / i_out_stall | o_pressed, o_hold_progress,
//           |           |                           | o_toggled, o_reanchored
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// accept to result register: S_SQX, S_SQY, S_SUM, then S_DONE when the anchor moves;
// otherwise S_TIME precedes S_DONE; progress adds S_DIV for the 16 restoring divider steps
// the next sample can be taken in the cycle after the result register loads
// the two squares share one 17x17 multiplier, one per cycle
// reset is synchronous active low; it clears anchor and pressed state, config goes to defaults
// a new sample is taken once the sequencer is idle, even while a result waits
// a stalled result only holds the sequencer in its last state once a new one is ready
module dwell_hold_toggle_detector
    import dhtd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [POS_W-1:0]     i_tip_x,
    input  logic [POS_W-1:0]     i_tip_y,
    input  logic [TIME_W-1:0]    i_now_ms,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_pressed,
    output logic [PROG_W-1:0]    o_hold_progress,
    output logic                 o_toggled,
    output logic                 o_reanchored,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DZ_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SUM,
        S_TIME,
        S_DIV,
        S_DONE
    } t_state;

    // config registers
    logic [DZ_W-1:0]   r_dead_zone_sq;
    logic [MS_W-1:0]   r_start_ms;
    logic [MS_W-1:0]   r_finish_ms;

    // sequencer and tracking state
    t_state            r_state;
    logic [POS_W-1:0]  r_x;
    logic [POS_W-1:0]  r_y;
    logic [TIME_W-1:0] r_now;
    logic [POS_W-1:0]  r_anchor_x;
    logic [POS_W-1:0]  r_anchor_y;
    logic [TIME_W-1:0] r_anchor_time;
    logic              r_anchor_valid;
    logic              r_pressed_state;
    logic [31:0]       r_prod;
    logic [31:0]       r_acc;
    logic [PROG_W-1:0] r_prog;
    logic              r_tog;
    logic              r_rea;

    // result register
    logic              r_out_valid;
    logic              r_out_pressed;
    logic [PROG_W-1:0] r_out_prog;
    logic              r_out_tog;
    logic              r_out_rea;

    logic              in_take;
    logic              out_free;
    logic [POS_W:0]    diff;
    logic [2*POS_W+1:0] sq;
    logic [32:0]       dist_sq;
    logic [TIME_W-1:0] elapsed;
    logic              past_finish;
    logic              past_start;
    logic              div_start;
    logic [MS_W-1:0]   div_num;
    logic [MS_W-1:0]   div_den;
    t_div_status       div_status;
    logic [PROG_W-1:0] div_quot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone_sq <= DEAD_ZONE_SQ_RST;
            r_start_ms     <= START_MS_RST;
            r_finish_ms    <= FINISH_MS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEAD_ZONE_SQ: r_dead_zone_sq <= i_cfg_data;
                CFG_START_MS:     r_start_ms     <= i_cfg_data[MS_W-1:0];
                CFG_FINISH_MS:    r_finish_ms    <= i_cfg_data[MS_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // shared multiplier: dx in the first square cycle, dy in the second
    always_comb begin
        if (r_state == S_SQX) begin
            diff = {r_x[POS_W-1], r_x} - {r_anchor_x[POS_W-1], r_anchor_x};
        end else begin
            diff = {r_y[POS_W-1], r_y} - {r_anchor_y[POS_W-1], r_anchor_y};
        end
        // sign extend to the full product width before squaring
        sq = $unsigned((2*POS_W+2)'($signed(diff)) * (2*POS_W+2)'($signed(diff)));
    end

    assign dist_sq = {1'b0, r_acc} + {1'b0, r_prod};

    // wrapping time difference, read as signed
    assign elapsed     = r_now - r_anchor_time;
    assign past_finish = !elapsed[TIME_W-1] && (elapsed > {16'd0, r_finish_ms});
    assign past_start  = !elapsed[TIME_W-1] && (elapsed > {16'd0, r_start_ms});

    // progress only starts when start < elapsed <= finish, so both fit 16 bits
    assign div_start = (r_state == S_TIME) && past_start && !past_finish;
    assign div_num   = elapsed[MS_W-1:0] - r_start_ms;
    assign div_den   = r_finish_ms - r_start_ms;

    dhtd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den    (div_den),
        .o_status (div_status),
        .o_quot   (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_anchor_x      <= '0;
            r_anchor_y      <= '0;
            r_anchor_time   <= '0;
            r_anchor_valid  <= 1'b0;
            r_pressed_state <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            // a result taken this cycle frees the register unless a new one loads
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_x     <= i_tip_x;
                        r_y     <= i_tip_y;
                        r_now   <= i_now_ms;
                        r_prog  <= '0;
                        r_tog   <= 1'b0;
                        r_rea   <= 1'b0;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_prod  <= sq[31:0];
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_acc   <= r_prod;
                    r_prod  <= sq[31:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // first sample, or finger left the dead zone: move the anchor
                    if (!r_anchor_valid || (dist_sq >= {1'b0, r_dead_zone_sq})) begin
                        r_anchor_x     <= r_x;
                        r_anchor_y     <= r_y;
                        r_anchor_time  <= r_now;
                        r_anchor_valid <= 1'b1;
                        r_rea          <= 1'b1;
                        r_state        <= S_DONE;
                    end else begin
                        r_state <= S_TIME;
                    end
                end
                S_TIME: begin
                    if (past_finish) begin
                        // hold completed
                        r_anchor_x      <= r_x;
                        r_anchor_y      <= r_y;
                        r_anchor_time   <= r_now;
                        r_pressed_state <= !r_pressed_state;
                        r_tog           <= 1'b1;
                        r_state         <= S_DONE;
                    end else if (past_start) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_status.done) begin
                        r_prog  <= div_quot;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_pressed <= r_pressed_state;
                        r_out_prog    <= r_prog;
                        r_out_tog     <= r_tog;
                        r_out_rea     <= r_rea;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pressed       = r_out_pressed;
    assign o_hold_progress = r_out_prog;
    assign o_toggled       = r_out_tog;
    assign o_reanchored    = r_out_rea;

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_toggled && o_reanchored))
        else $error("result both toggled and reanchored");

    a_progress_alone : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_hold_progress != '0)) |-> (!o_toggled && !o_reanchored))
        else $error("progress reported on an anchor move");

    a_progress_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hold_progress <= Q_ONE))
        else $error("progress above one");

    a_div_only_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_status.busy |-> (r_state == S_DIV))
        else $error("divider running outside its state");

endmodule

// File: hw/rtl/dhtd_div.sv
module dhtd_div
    import dhtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MS_W-1:0]   i_num,
    input  logic [MS_W-1:0]   i_den,
    output t_div_status       o_status,
    output logic [PROG_W-1:0] o_quot
);

    // (i_num * 2^15) / i_den with i_num <= i_den, one quotient bit a cycle
    localparam int unsigned CNT_W = $clog2(PROG_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MS_W:0]     r_rem;
    logic [MS_W-1:0]   r_den;
    logic [PROG_W-1:0] r_quot;

    logic              ge;
    logic [MS_W:0]     rem_sub;

    always_comb begin
        ge      = (r_rem >= {1'b0, r_den});
        rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROG_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {rem_sub[MS_W-1:0], 1'b0};
            r_quot <= {r_quot[PROG_W-2:0], ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_den_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_den != '0))
        else $error("divider started with zero divisor");

endmodule
